>>> rtl/core/tet_gradient_operator_entries_core_assert.svh
// Assertion macros for the tetrahedron gradient-operator core.
`ifndef TET_GRADIENT_OPERATOR_ENTRIES_CORE_ASSERT_SVH
`define TET_GRADIENT_OPERATOR_ENTRIES_CORE_ASSERT_SVH

// Same-cycle implication, checked on the rising edge of clock.
`define TGO_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tgo: same-cycle check failed");

// Next-cycle implication.
`define TGO_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tgo: next-cycle check failed");

`endif

>>> rtl/core/tgo_pkg.sv
// Package: types, widths and index helpers of the gradient-operator core.
`timescale 1ns / 1ps
`default_nettype none
package tgo_pkg;

   localparam int MAX_VERTS_DEF = 65536;
   localparam int MAX_TETS_DEF  = 65536;

   localparam int DW    = 33;   // edge difference
   localparam int BW    = 35;   // second multiplier operand
   localparam int PW    = 68;   // product
   localparam int CW    = 67;   // cofactor
   localparam int NW    = 69;   // numerator
   localparam int DETW  = 102;  // determinant
   localparam int QBITS = 32;   // quotient bits
   localparam int CNTW  = $clog2(QBITS + 1);

   localparam logic [4:0] OP_DET_FIRST = 5'd18;
   localparam logic [4:0] OP_LAST      = 5'd23;
   localparam logic [3:0] ENT_LAST     = 4'd11;
   localparam logic [1:0] KIND_MAX_OK  = 2'd1;
   localparam logic       REG_ENERGY_KIND = 1'b0;

   typedef enum logic [6:0] {
      S_IDLE      = 7'b0000001,
      S_MUL_ISSUE = 7'b0000010,
      S_MUL_TAKE  = 7'b0000100,
      S_PREP      = 7'b0001000,
      S_DIV_START = 7'b0010000,
      S_DIV_RUN   = 7'b0100000,
      S_EMIT      = 7'b1000000
   } state_type;

   typedef struct packed {
      logic              done;
      logic [QBITS-1:0]  quotient;
   } div_status_type;

   // Row index 0..2 from cofactor number 0..8.
   function automatic logic [1:0] row_of(input logic [3:0] k);
      logic [1:0] r;
      r = (k >= 4'd6) ? 2'd2 : ((k >= 4'd3) ? 2'd1 : 2'd0);
      return r;
   endfunction

   // Edge-matrix index for one term of a cofactor.
   // sel 0: (i+1,j+1) 1: (i+2,j+2) 2: (i+1,j+2) 3: (i+2,j+1)
   function automatic logic [3:0] cof_src(input logic [3:0] k, input logic [1:0] sel);
      logic [1:0] i, j, i1, i2, j1, j2, rr, cc;
      i  = row_of(k);
      j  = 2'(k - 4'(3 * i));
      i1 = (i == 2'd2) ? 2'd0 : 2'(i + 2'd1);
      i2 = (i == 2'd0) ? 2'd2 : 2'(i - 2'd1);
      j1 = (j == 2'd2) ? 2'd0 : 2'(j + 2'd1);
      j2 = (j == 2'd0) ? 2'd2 : 2'(j - 2'd1);
      case (sel)
         2'd0: begin rr = i1; cc = j1; end
         2'd1: begin rr = i2; cc = j2; end
         2'd2: begin rr = i1; cc = j2; end
         default: begin rr = i2; cc = j1; end
      endcase
      return 4'(3 * rr + cc);
   endfunction

   // Corner (0..3) of an output entry number 0..11.
   function automatic logic [1:0] ent_row(input logic [3:0] e);
      logic [1:0] r;
      r = (e >= 4'd9) ? 2'd3 : ((e >= 4'd6) ? 2'd2 : ((e >= 4'd3) ? 2'd1 : 2'd0));
      return r;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/tgo_mul.sv
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none
module tgo_mul (
   input  logic                           clock,
   input  logic signed [tgo_pkg::DW-1:0]  op_a,
   input  logic signed [tgo_pkg::BW-1:0]  op_b,
   output logic signed [tgo_pkg::PW-1:0]  prod_ff
);
   import tgo_pkg::*;

   logic signed [PW-1:0] prod_in;

   assign prod_in = PW'(op_a) * PW'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule
`default_nettype wire

>>> rtl/core/tgo_div.sv
// Restoring divider, one quotient bit per cycle; expects num < den.
`timescale 1ns / 1ps
`default_nettype none
module tgo_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tgo_pkg::DETW-1:0]      num,
   input  logic [tgo_pkg::DETW-1:0]      den,
   output tgo_pkg::div_status_type       status
);
   import tgo_pkg::*;

   logic [DETW-1:0]  rem_ff, rem_in;
   logic [QBITS-1:0] quo_ff, quo_in;
   logic [CNTW-1:0]  cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DETW:0]    shifted;

   always_comb begin
      shifted = {rem_ff, 1'b0};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num;
         quo_in  = '0;
         cnt_in  = CNTW'(QBITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den}) begin
            rem_in = DETW'(shifted - {1'b0, den});
            quo_in = {quo_ff[QBITS-2:0], 1'b1};
         end else begin
            rem_in = shifted[DETW-1:0];
            quo_in = {quo_ff[QBITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNTW'(1);
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign status.done     = done_ff;
   assign status.quotient = quo_ff;

endmodule
`default_nettype wire

>>> rtl/core/tet_gradient_operator_entries_core.sv
// Top level: tetrahedron gradient-operator entry generator.
//
//  channel | dir | items
//  req_*   | in  | one tetrahedron corner per item, four per tetrahedron
//  rsp_*   | out | twelve sparse entries per tetrahedron, tlast on the twelfth
//  csr_*   | cfg | energy_kind at byte address 0
//
// Corners 0..2 are stored as they arrive. The fourth corner starts the
// sequencer if all ids are in range and energy_kind is valid: 24 products on
// the shared multiplier, each issued and then taken, the determinant sign, then
// per entry a setup state, the divider state for the 32 quotient bits (skipped
// for a singular or saturated entry) and an output state. req_tready is low
// while this runs and while an entry waits on rsp_tready. Reset is synchronous;
// corner storage is not reset.
`timescale 1ns / 1ps
`default_nettype none
module tet_gradient_operator_entries_core #(
   parameter int MAX_VERTS = tgo_pkg::MAX_VERTS_DEF,
   parameter int MAX_TETS  = tgo_pkg::MAX_TETS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   // req_tdata: vertex_id[15:0], tet_index[31:16], x_coord[63:32],
   //            y_coord[95:64], z_coord[127:96]
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [127:0]  req_tdata,
   // rsp_tdata: row_vertex[15:0], column[33:16], entry_value[65:34],
   //            singular[66], zero[71:67]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [71:0]   rsp_tdata,
   output logic          rsp_tlast,
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [2:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);
   import tgo_pkg::*;

   localparam logic [24:0] VLIM = 25'(MAX_VERTS);
   localparam logic [24:0] TLIM = 25'(MAX_TETS);

   // input fields
   logic [15:0]        in_vid, in_tet;
   logic signed [31:0] in_x, in_y, in_z;

   // control
   state_type   state_ff, state_in;
   logic [1:0]  count_ff, count_in;
   logic [1:0]  kind_ff, kind_in;
   logic [4:0]  op_ff, op_in;
   logic [3:0]  ent_ff, ent_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // corner storage (written before read)
   logic signed [31:0] cx_ff [3];
   logic signed [31:0] cy_ff [3];
   logic signed [31:0] cz_ff [3];
   logic [15:0]        cid_ff [3];
   logic [15:0]        vid3_ff, vid3_in;
   logic [15:0]        tet_ff, tet_in;

   // arithmetic state
   logic signed [DW-1:0]   d_ff [9];
   logic signed [PW-1:0]   acc_ff, acc_in;
   logic signed [CW-1:0]   cof_ff [9];
   logic signed [DETW-1:0] det_ff, det_in;
   logic [DETW-1:0]        det_abs_ff, det_abs_in;
   logic                   det_neg_ff, det_neg_in;
   logic                   sing_ff, sing_in;
   logic                   neg_ff, neg_in;

   // output payload
   logic [15:0] row_ff, row_in;
   logic [17:0] col_ff, col_in;
   logic [31:0] val_ff, val_in;
   logic        last_ff, last_in;

   // multiplier
   logic signed [DW-1:0] mul_a;
   logic signed [BW-1:0] mul_b;
   logic signed [PW-1:0] mul_p;
   logic [3:0]           cof_k, src_a, src_b;
   logic [4:0]           det_op;
   logic [1:0]           det_j;
   logic signed [CW-1:0] det_cof;

   // divider
   logic                 div_start;
   logic [DETW-1:0]      div_num;
   div_status_type       div_status;

   // entry setup
   logic [1:0]           e_row, e_col;
   logic signed [NW-1:0] num, num_sum;
   logic [NW-1:0]        num_abs;
   logic                 q_neg;
   logic [QBITS-1:0]     q;

   logic accept, cfg_write, ids_ok, kind_ok;

   assign in_vid = req_tdata[15:0];
   assign in_tet = req_tdata[31:16];
   assign in_x   = req_tdata[63:32];
   assign in_y   = req_tdata[95:64];
   assign in_z   = req_tdata[127:96];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   // configuration port
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_ENERGY_KIND) ? {30'b0, kind_ff} : 32'b0;

   assign kind_ok = (kind_ff <= KIND_MAX_OK);
   assign ids_ok  = ({9'b0, cid_ff[0]} < VLIM) && ({9'b0, cid_ff[1]} < VLIM) &&
                    ({9'b0, cid_ff[2]} < VLIM) && ({9'b0, in_vid} < VLIM) &&
                    ({9'b0, in_tet} < TLIM);

   // operand selection: ops 0..17 build cofactors as pairs of products,
   // ops 18..23 add D(0,j) times the low and high halves of cof(0,j)
   assign cof_k   = op_ff[4:1];
   assign det_op  = op_ff - OP_DET_FIRST;
   assign det_j   = det_op[2:1];
   assign src_a   = cof_src(cof_k, op_ff[0] ? 2'd2 : 2'd0);
   assign src_b   = cof_src(cof_k, op_ff[0] ? 2'd3 : 2'd1);
   assign det_cof = cof_ff[4'(det_j)];

   always_comb begin
      if (op_ff < OP_DET_FIRST) begin
         mul_a = d_ff[src_a];
         mul_b = {{(BW-DW){d_ff[src_b][DW-1]}}, d_ff[src_b]};
      end else begin
         mul_a = d_ff[4'(det_j)];
         if (det_op[0]) begin
            mul_b = {{(BW-(CW-34)){det_cof[CW-1]}}, det_cof[CW-1:34]};
         end else begin
            mul_b = {1'b0, det_cof[33:0]};
         end
      end
   end

   tgo_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (mul_p)
   );

   // entry numerator: a cofactor, or the negated sum over a cofactor row
   assign e_row   = ent_row(ent_ff);
   assign e_col   = 2'(ent_ff - 4'(3 * e_row));
   assign num_sum = NW'(cof_ff[4'(3 * e_col)]) + NW'(cof_ff[4'(3 * e_col + 1)]) +
                    NW'(cof_ff[4'(3 * e_col + 2)]);
   assign num     = (e_row == 2'd3) ? -num_sum : NW'(cof_ff[4'(3 * e_col + e_row)]);
   assign num_abs = num[NW-1] ? NW'(-num) : NW'(num);
   assign div_num = DETW'(num_abs);

   tgo_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (det_abs_ff),
      .status (div_status)
   );

   assign q = div_status.quotient;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      kind_in      = kind_ff;
      op_in        = op_ff;
      ent_in       = ent_ff;
      rsp_valid_in = rsp_valid_ff;
      vid3_in      = vid3_ff;
      tet_in       = tet_ff;
      acc_in       = acc_ff;
      det_in       = det_ff;
      det_abs_in   = det_abs_ff;
      det_neg_in   = det_neg_ff;
      sing_in      = sing_ff;
      neg_in       = neg_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      val_in       = val_ff;
      last_in      = last_ff;
      div_start    = 1'b0;
      q_neg        = 1'b0;

      if (cfg_write && (csr_paddr[2] == REG_ENERGY_KIND)) begin
         kind_in = csr_pwdata[1:0];
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (count_ff != 2'd3) begin
                  count_in = count_ff + 2'd1;
               end else begin
                  count_in = 2'd0;
                  if (kind_ok && ids_ok) begin
                     vid3_in  = in_vid;
                     tet_in   = in_tet;
                     det_in   = '0;
                     op_in    = '0;
                     state_in = S_MUL_ISSUE;
                  end
               end
            end
         end
         S_MUL_ISSUE: begin
            state_in = S_MUL_TAKE;
         end
         S_MUL_TAKE: begin
            if (op_ff < OP_DET_FIRST) begin
               if (!op_ff[0]) begin
                  acc_in = mul_p;
               end
            end else if (det_op[0]) begin
               det_in = det_ff + {mul_p, 34'b0};
            end else begin
               det_in = det_ff + {{(DETW-PW){mul_p[PW-1]}}, mul_p};
            end
            op_in = op_ff + 5'd1;
            state_in = (op_ff == OP_LAST) ? S_PREP : S_MUL_ISSUE;
         end
         S_PREP: begin
            det_neg_in = det_ff[DETW-1];
            det_abs_in = det_ff[DETW-1] ? DETW'(-det_ff) : DETW'(det_ff);
            sing_in    = (det_ff == '0);
            ent_in     = '0;
            state_in   = S_DIV_START;
         end
         S_DIV_START: begin
            row_in  = (e_row == 2'd3) ? vid3_ff : cid_ff[e_row];
            col_in  = 18'({2'b0, tet_ff}) + 18'({1'b0, tet_ff, 1'b0}) + 18'(e_col);
            last_in = (ent_ff == ENT_LAST);
            q_neg   = num[NW-1] ^ det_neg_ff;
            neg_in  = q_neg;
            if (sing_ff) begin
               val_in       = '0;
               rsp_valid_in = 1'b1;
               state_in     = S_EMIT;
            end else if (div_num >= det_abs_ff) begin
               // quotient at least 2^32: saturate
               val_in       = q_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
               rsp_valid_in = 1'b1;
               state_in     = S_EMIT;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV_RUN;
            end
         end
         S_DIV_RUN: begin
            if (div_status.done) begin
               if (neg_ff) begin
                  val_in = (q > 32'h8000_0000) ? 32'h8000_0000 : (~q + 32'd1);
               end else begin
                  val_in = (q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q;
               end
               rsp_valid_in = 1'b1;
               state_in     = S_EMIT;
            end
         end
         S_EMIT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (ent_ff == ENT_LAST) begin
                  state_in = S_IDLE;
               end else begin
                  ent_in   = ent_ff + 4'd1;
                  state_in = S_DIV_START;
               end
            end
         end
         default: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         kind_ff      <= '0;
         op_ff        <= '0;
         ent_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         kind_ff      <= kind_in;
         op_ff        <= op_in;
         ent_ff       <= ent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      vid3_ff    <= vid3_in;
      tet_ff     <= tet_in;
      acc_ff     <= acc_in;
      det_ff     <= det_in;
      det_abs_ff <= det_abs_in;
      det_neg_ff <= det_neg_in;
      sing_ff    <= sing_in;
      neg_ff     <= neg_in;
      row_ff     <= row_in;
      col_ff     <= col_in;
      val_ff     <= val_in;
      last_ff    <= last_in;
      // corners 0..2 kept as they arrive
      if (accept && (count_ff != 2'd3)) begin
         cx_ff[count_ff]  <= in_x;
         cy_ff[count_ff]  <= in_y;
         cz_ff[count_ff]  <= in_z;
         cid_ff[count_ff] <= in_vid;
      end
      // edge matrix: D(r,c) = corner c minus corner 3, row r is x, y, z
      if (accept && (count_ff == 2'd3)) begin
         for (int c = 0; c < 3; c++) begin
            d_ff[c]     <= DW'(cx_ff[c]) - DW'(in_x);
            d_ff[3 + c] <= DW'(cy_ff[c]) - DW'(in_y);
            d_ff[6 + c] <= DW'(cz_ff[c]) - DW'(in_z);
         end
      end
      if ((state_ff == S_MUL_TAKE) && (op_ff < OP_DET_FIRST) && op_ff[0]) begin
         cof_ff[cof_k] <= CW'(acc_ff - mul_p);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {5'b0, sing_ff, val_ff, col_ff, row_ff};

   `include "tet_gradient_operator_entries_core_assert.svh"

   // no new corner is taken while an entry is on offer
   `TGO_ASSERT_NOW(a_no_accept_while_out, accept, !rsp_tvalid)
   // singular tetrahedra give zero coefficients
   `TGO_ASSERT_NOW(a_singular_zero, rsp_tvalid && rsp_tdata[66], rsp_tdata[65:34] == 32'b0)
   // the block is ready again right after the twelfth entry leaves
   `TGO_ASSERT_NEXT(a_ready_after_last, rsp_tvalid && rsp_tready && rsp_tlast, req_tready)

endmodule
`default_nettype wire
